@@ sv/mic_pkg.sv @@
// Shared types and constants for the magnetometer iron calibration unit.
// No dependencies; imported by every module of the block.
package mic_pkg;

  localparam int NumAxes    = 3;
  localparam int AxisW      = 16;
  localparam int SumW       = AxisW + 1;
  localparam int CoefW      = 16;
  localparam int ProdW      = CoefW + SumW;
  localparam int AccW       = ProdW + 2;
  localparam int OutW       = 32;
  localparam int FracBits   = 8;
  localparam int RoundShift = 4;
  localparam int RegW       = NumAxes * AxisW;
  localparam int CfgIdxW    = 3;
  localparam int InDataW    = 48;
  localparam int OutDataW   = NumAxes * OutW;

  localparam logic [RegW-1:0] HardReset = '0;
  localparam logic [RegW-1:0] Row0Reset = RegW'(48'h0000_0000_1000);
  localparam logic [RegW-1:0] Row1Reset = RegW'(48'h0000_1000_0000);
  localparam logic [RegW-1:0] Row2Reset = RegW'(48'h1000_0000_0000);

  typedef logic signed [AxisW-1:0] axis_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [OutW-1:0]  res_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HARD  = 3'd0,
    CFG_ROW0  = 3'd1,
    CFG_ROW1  = 3'd2,
    CFG_ROW2  = 3'd3,
    CFG_VALID = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    axis_t [NumAxes-1:0] raw;
    sum_t  [NumAxes-1:0] vec;
    logic                cal;
  } front_t;

endpackage

@@ sv/mic_front.sv @@
// Burst unpack, axis remap with saturating negation and hard-iron offset add.
// Depends on mic_pkg.
module mic_front
  import mic_pkg::*;
(
  input  logic [InDataW-1:0] burst,
  input  logic [RegW-1:0]    hard_offsets,
  input  logic               cal_valid,
  output front_t             front
);

  axis_t sx;
  axis_t sy;
  axis_t sz;
  axis_t off;

  always_comb begin
    sx = {burst[7:0],   burst[15:8]};
    sz = {burst[23:16], burst[31:24]};
    sy = {burst[39:32], burst[47:40]};
    front.raw[0] = sy;
    front.raw[1] = (sx == 16'sh8000) ? 16'sh7fff : axis_t'(-sx);
    front.raw[2] = sz;
    front.cal    = cal_valid;
    off          = '0;
    for (int j = 0; j < NumAxes; j++) begin
      off          = hard_offsets[j*AxisW +: AxisW];
      front.vec[j] = sum_t'(front.raw[j]) + sum_t'(off);
    end
  end

endmodule

@@ sv/mic_lane.sv @@
// One soft-iron matrix row times the offset-corrected vector, three products.
// Depends on mic_pkg.
module mic_lane
  import mic_pkg::*;
(
  input  logic [RegW-1:0]     row,
  input  sum_t [NumAxes-1:0]  vec,
  output prod_t [NumAxes-1:0] prod
);

  logic signed [CoefW-1:0] coef [NumAxes];

  always_comb begin
    for (int j = 0; j < NumAxes; j++) begin
      coef[j] = row[j*CoefW +: CoefW];
      prod[j] = prod_t'(coef[j]) * prod_t'(vec[j]);
    end
  end

endmodule

@@ sv/mic_merge.sv @@
// Lane merge: sum of products, round Q.12 to Q23.8, or raw pass-through.
// Depends on mic_pkg.
module mic_merge
  import mic_pkg::*;
(
  input  prod_t [NumAxes-1:0] prod,
  input  axis_t               raw,
  input  logic                cal,
  output res_t                res
);

  logic signed [AccW-1:0] acc;

  always_comb begin
    acc = AccW'(prod[0]) + AccW'(prod[1]) + AccW'(prod[2]) + AccW'(8);
    if (cal) begin
      res = res_t'(acc >>> RoundShift);
    end else begin
      res = {{(OutW-AxisW-FracBits){raw[AxisW-1]}}, raw, {FracBits{1'b0}}};
    end
  end

endmodule

@@ sv/magnetometer_iron_calibration_unit.sv @@
// Magnetometer hard/soft-iron calibration unit, top level.
// Pipeline: each burst is registered in the front, lane and output regs, in that order.
// Throughput: one burst per cycle unless out_tready stalls; each stage advances when its successor frees up.
// Reset (rst_n, synchronous): stages empty, offsets zero, identity matrix, cal off.
// Depends on mic_pkg, mic_front, mic_lane and mic_merge.
module magnetometer_iron_calibration_unit
  import mic_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // x_msb, x_lsb, z_msb, z_lsb, y_msb, y_lsb from bit 0 up
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // x_out, y_out, z_out from bit 0 up
  output logic [OutDataW-1:0] out_tdata,
  // status
  output logic                out_tuser,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [RegW-1:0]     cfg_data
);

  logic [RegW-1:0]              hard_r;
  logic [NumAxes-1:0][RegW-1:0] soft_r;
  logic                         cal_r;

  front_t                            front;
  logic                              s1_v_r;
  front_t                            s1_r;
  logic                              s2_v_r;
  prod_t [NumAxes-1:0][NumAxes-1:0]  lane_prod;
  prod_t [NumAxes-1:0][NumAxes-1:0]  s2_prod_r;
  axis_t [NumAxes-1:0]               s2_raw_r;
  logic                              s2_cal_r;
  res_t  [NumAxes-1:0]               res;
  logic                              out_v_r;
  logic [OutDataW-1:0]               out_data_r;
  logic                              out_user_r;

  logic out_en;
  logic s2_en;
  logic s1_en;

  assign out_en    = !out_v_r || out_tready;
  assign s2_en     = !s2_v_r || out_en;
  assign s1_en     = !s1_v_r || s2_en;
  assign in_tready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_r    <= HardReset;
      soft_r[0] <= Row0Reset;
      soft_r[1] <= Row1Reset;
      soft_r[2] <= Row2Reset;
      cal_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_HARD:  hard_r    <= cfg_data;
        CFG_ROW0:  soft_r[0] <= cfg_data;
        CFG_ROW1:  soft_r[1] <= cfg_data;
        CFG_ROW2:  soft_r[2] <= cfg_data;
        CFG_VALID: cal_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mic_front u_front (
    .burst        (in_tdata),
    .hard_offsets (hard_r),
    .cal_valid    (cal_r),
    .front        (front)
  );

  for (genvar i = 0; i < NumAxes; i++) begin : g_lane
    mic_lane u_lane (
      .row  (soft_r[i]),
      .vec  (s1_r.vec),
      .prod (lane_prod[i])
    );

    mic_merge u_merge (
      .prod (s2_prod_r[i]),
      .raw  (s2_raw_r[i]),
      .cal  (s2_cal_r),
      .res  (res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_en) s1_v_r <= in_tvalid;
      if (s2_en) s2_v_r <= s1_v_r;
      if (out_en) out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_tvalid) begin
      s1_r <= front;
    end
    if (s2_en && s1_v_r) begin
      s2_prod_r <= lane_prod;
      s2_raw_r  <= s1_r.raw;
      s2_cal_r  <= s1_r.cal;
    end
    if (out_en && s2_v_r) begin
      out_data_r <= {res[2], res[1], res[0]};
      out_user_r <= !s2_cal_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_free_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_raw_frac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[7:0] == 8'h00 && out_tdata[39:32] == 8'h00
      && out_tdata[71:64] == 8'h00))
    else $error("raw pass-through with nonzero fraction");

  a_raw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[31:23] == 9'h000 || out_tdata[31:23] == 9'h1ff))
    else $error("raw pass-through exceeds 16-bit range");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !out_en) |=> s2_v_r)
    else $error("lane stage dropped an item while stalled");
`endif

endmodule
